@@ rtl/core/wmf_pkg.sv @@
// Shared types, register codes and constants of the window majority filter.
package wmf_pkg;

    // Data path width of pixels and register values
    localparam int DATA_W = 32;

    // Default window limits
    localparam int DEF_MAX_ROWS = 7;
    localparam int DEF_MAX_COLS = 7;

    // Width of the center index computed from the 3-bit window registers
    localparam int CIDX_W = 6;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_ROWS  = 2'd1;
    localparam logic [1:0] CFG_COLS  = 2'd2;
    localparam logic [1:0] CFG_UNDEF = 2'd3;

    // Mode codes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_UNDEF  = 2'd1;
    localparam logic [1:0] MODE_ZERO   = 2'd2;

    // Register reset values
    localparam logic [1:0]        RST_MODE  = MODE_NORMAL;
    localparam logic [2:0]        RST_ROWS  = 3'd3;
    localparam logic [2:0]        RST_COLS  = 3'd3;
    localparam logic [DATA_W-1:0] RST_UNDEF = 32'h8000_0001;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic count_en;  // count the broadcast pixel this cycle
        logic scan;      // shift contents one cell toward the head
    } t_cell_ctl;

endpackage

@@ rtl/core/wmf_cell.sv @@
// One cell of the value table: holds a distinct value and its count.
module wmf_cell
    import wmf_pkg::*;
#(
    parameter int CNT_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_pixel,
    input  logic              i_any_match,
    input  logic              i_prev_valid,
    input  logic              i_next_valid,
    input  logic [DATA_W-1:0] i_next_value,
    input  logic [CNT_W-1:0]  i_next_count,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_value,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_match
);

    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count;
    logic              w_append;

    assign o_match  = r_valid && (r_value == i_pixel);
    // First free cell takes a value not yet in the table
    assign w_append = !i_any_match && !r_valid && i_prev_valid;

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.scan) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.count_en && w_append) begin
            r_valid <= 1'b1;
        end
    end

    // Value and count
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_value <= i_next_value;
            r_count <= i_next_count;
        end else if (i_ctl.count_en) begin
            if (o_match) begin
                r_count <= r_count + 1'b1;
            end else if (w_append) begin
                r_value <= i_pixel;
                r_count <= CNT_W'(1);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_count = r_count;

endmodule

@@ rtl/core/wmf_pick.sv @@
// Head of the chain: finds the first highest count and the center's count.
module wmf_pick
    import wmf_pkg::*;
#(
    parameter int CNT_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_value,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_center,
    output logic [DATA_W-1:0] o_best_value,
    output logic [CNT_W-1:0]  o_best_count,
    output logic [CNT_W-1:0]  o_center_count
);

    logic [DATA_W-1:0] r_best_value;
    logic [CNT_W-1:0]  r_best_count;
    logic [CNT_W-1:0]  r_center_count;

    // Strict compare keeps the earliest first occurrence on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best_count   <= '0;
            r_center_count <= '0;
        end else if (i_step) begin
            if (i_count > r_best_count) begin
                r_best_count <= i_count;
            end
            if (i_value == i_center) begin
                r_center_count <= i_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && (i_count > r_best_count)) begin
            r_best_value <= i_value;
        end
    end

    assign o_best_value   = r_best_value;
    assign o_best_count   = r_best_count;
    assign o_center_count = r_center_count;

endmodule

@@ rtl/core/window_majority_filter_top.sv @@
// Top level of the window majority filter: control, registers and cell chain.
//
// Usage: window elements enter one per cycle in row-major order on i_pixel,
// accepted when i_start is high and o_busy is low; i_window_end marks the
// last element of a window. Elements past MAX_ROWS*MAX_COLS in a window are
// not counted but the end flag still closes the window.
// After the last element the table of distinct values shifts through the
// head of the cell chain, one entry a cycle, while o_busy is high; the table
// holds at most MAX_ROWS*MAX_COLS distinct values. o_done then pulses for one
// cycle with o_majority. Within a window one element is taken every cycle;
// the scan of the chain sets the gap between windows. The shift also empties
// the table for the next window. Configuration is written over
// i_cfg_valid/o_cfg_ready (always ready); the user must write it only while
// the block is idle, and the block itself does not enforce this. Reset
// returns the registers to their defaults and empties the table. The
// receiver cannot stall o_done.
module window_majority_filter_top
    import wmf_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [DATA_W-1:0] i_pixel,
    input  logic              i_window_end,
    output logic              o_done,
    output logic [DATA_W-1:0] o_majority,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    localparam int N     = MAX_ROWS * MAX_COLS;
    localparam int CNT_W = $clog2(N + 1);
    localparam int POS_W = $clog2(N + 1);
    localparam int CMP_W = (POS_W > CIDX_W) ? POS_W : CIDX_W;

    localparam logic S_COLLECT = 1'b0;
    localparam logic S_SCAN    = 1'b1;

    // Configuration registers
    logic [1:0]        r_mode;
    logic [2:0]        r_rows;
    logic [2:0]        r_cols;
    logic [DATA_W-1:0] r_undef;

    // Window control
    logic              r_state;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_center;
    logic              r_center_seen;
    logic              r_done;
    logic [DATA_W-1:0] r_majority;
    logic              n_state;
    logic              n_done;
    logic [DATA_W-1:0] n_majority;

    logic              w_accept;
    logic              w_ignoring;
    logic [DATA_W-1:0] w_ignored;
    logic [2:0]        w_width;
    logic [CIDX_W-1:0] w_cidx;
    logic              w_pos_ok;
    logic              w_at_center;
    logic              w_any_match;
    t_cell_ctl         w_ctl;

    logic [N:0]              w_valid;
    logic [DATA_W-1:0]       w_value [N+1];
    logic [CNT_W-1:0]        w_count [N+1];
    logic [N-1:0]            w_match;
    logic [DATA_W-1:0]       w_best_value;
    logic [CNT_W-1:0]        w_best_count;
    logic [CNT_W-1:0]        w_center_count;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state == S_SCAN);
    assign w_accept    = i_start && !o_busy;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_rows  <= RST_ROWS;
            r_cols  <= RST_COLS;
            r_undef <= RST_UNDEF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_ROWS:  r_rows  <= i_cfg_data[2:0];
                CFG_COLS:  r_cols  <= i_cfg_data[2:0];
                CFG_UNDEF: r_undef <= i_cfg_data;
                default:   r_undef <= r_undef;
            endcase
        end
    end

    // Mode decode and center position (odd width in use)
    assign w_ignoring = (r_mode == MODE_UNDEF) || (r_mode == MODE_ZERO);
    assign w_ignored  = (r_mode == MODE_UNDEF) ? r_undef : '0;
    assign w_width    = {r_cols[2:1], 1'b1};
    assign w_cidx     = ({4'b0, r_rows[2:1]} * {3'b0, w_width}) + {4'b0, r_cols[2:1]};
    assign w_pos_ok   = (r_pos < POS_W'(N));
    assign w_at_center = (CMP_W'(r_pos) == CMP_W'(w_cidx));

    // Cell control
    assign w_ctl.count_en = w_accept && w_pos_ok && !(w_ignoring && (i_pixel == w_ignored));
    assign w_ctl.scan     = (r_state == S_SCAN);
    assign w_any_match    = |w_match;

    // Chain of cells; the tail is fed empty entries during the scan
    assign w_valid[N] = 1'b0;
    assign w_value[N] = '0;
    assign w_count[N] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic w_prev_valid;
        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end
        wmf_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_pixel      (i_pixel),
            .i_any_match  (w_any_match),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_valid[g+1]),
            .i_next_value (w_value[g+1]),
            .i_next_count (w_count[g+1]),
            .o_valid      (w_valid[g]),
            .o_value      (w_value[g]),
            .o_count      (w_count[g]),
            .o_match      (w_match[g])
        );
    end

    // Resolver at the head of the chain
    wmf_pick #(
        .CNT_W (CNT_W)
    ) u_pick (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (w_accept && i_window_end),
        .i_step         ((r_state == S_SCAN) && w_valid[0]),
        .i_value        (w_value[0]),
        .i_count        (w_count[0]),
        .i_center       (r_center),
        .o_best_value   (w_best_value),
        .o_best_count   (w_best_count),
        .o_center_count (w_center_count)
    );

    // Position and center capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_center      <= '0;
            r_center_seen <= 1'b0;
        end else if (w_accept) begin
            if (i_window_end) begin
                r_pos <= '0;
            end else if (w_pos_ok) begin
                r_pos <= r_pos + 1'b1;
            end
            if (w_pos_ok && w_at_center && !i_window_end) begin
                r_center      <= i_pixel;
                r_center_seen <= 1'b1;
            end else if (w_pos_ok && w_at_center) begin
                r_center      <= i_pixel;
                r_center_seen <= 1'b1;
            end
        end else if (n_done) begin
            r_center      <= '0;
            r_center_seen <= 1'b0;
        end
    end

    // Sequencer and result selection
    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_majority = r_majority;
        case (r_state)
            S_COLLECT: begin
                if (w_accept && i_window_end) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_valid[0]) begin
                    n_state = S_COLLECT;
                    n_done  = 1'b1;
                    if (w_ignoring && r_center_seen && (r_center != w_ignored)) begin
                        n_majority = r_center;
                    end else if (w_best_count == '0) begin
                        n_majority = r_undef;
                    end else if (!w_ignoring && r_center_seen
                                 && (w_center_count == w_best_count)) begin
                        n_majority = r_center;
                    end else begin
                        n_majority = w_best_value;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_majority <= n_majority;
    end

    assign o_done     = r_done;
    assign o_majority = r_majority;

    // A value lives in at most one cell
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("value matched in more than one cell");

    // A result only follows a finished scan
    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_SCAN))
        else $error("result strobe without a scan");

    // Table is empty when the result leaves
    a_empty_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !w_valid[0])
        else $error("table not emptied by the scan");

    // Position counter saturates at the table size
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(N))
        else $error("position beyond table size");

endmodule
